// ===== src/htc_pkg.sv =====
package htc_pkg;

   localparam int MAX_POLY_VERTS = 9;
   localparam int FRAC_BITS      = 16;
   localparam int VAL_W          = 32;
   localparam int NUM_FIELDS     = 6;
   localparam int W_FIELD        = 3;
   localparam int NUM_PLANES     = 6;
   localparam int STORE_DEPTH    = 2 * MAX_POLY_VERTS;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int IDX_W          = $clog2(MAX_POLY_VERTS + 1);
   localparam int VERT_W         = NUM_FIELDS * VAL_W;
   localparam int DIST_W         = VAL_W + 2;
   localparam int DEN_W          = DIST_W + 1;
   localparam int QUOT_W         = FRAC_BITS + 1;
   localparam int REM_W          = DEN_W + FRAC_BITS;
   localparam int DELTA_W        = VAL_W + 1;
   localparam int PROD_W         = DELTA_W + QUOT_W;
   localparam int PLANE_W        = 3;

   localparam logic [1:0] SLOT_LAST = 2'd2;

   typedef logic [NUM_FIELDS-1:0][VAL_W-1:0] vert_type;

   typedef struct packed {
      logic [1:0]              vertex_slot;
      logic signed [VAL_W-1:0] pos_x;
      logic signed [VAL_W-1:0] pos_y;
      logic signed [VAL_W-1:0] pos_z;
      logic signed [VAL_W-1:0] pos_w;
      logic signed [VAL_W-1:0] attr_a;
      logic signed [VAL_W-1:0] attr_b;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_x;
      logic signed [VAL_W-1:0] out_y;
      logic signed [VAL_W-1:0] out_z;
      logic signed [VAL_W-1:0] out_w;
      logic signed [VAL_W-1:0] out_attr_a;
      logic signed [VAL_W-1:0] out_attr_b;
      logic                    last_vertex;
      logic                    culled;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [REM_W-1:0]  rem;
      logic [REM_W-1:0]  dsh;
      logic [QUOT_W-1:0] quot;
   } div_stage_type;

   function automatic logic [ADDR_W-1:0] store_addr(input logic bank,
                                                    input logic [IDX_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      base = bank ? ADDR_W'(MAX_POLY_VERTS) : '0;
      return base + ADDR_W'(idx);
   endfunction

   function automatic logic signed [DIST_W-1:0] plane_dist(input vert_type v,
                                                           input logic [PLANE_W-1:0] plane);
      logic signed [DIST_W-1:0] w;
      logic signed [DIST_W-1:0] c;
      w = DIST_W'(signed'(v[W_FIELD]));
      c = DIST_W'(signed'(v[plane[PLANE_W-1:1]]));
      return plane[0] ? w + c : w - c;
   endfunction

endpackage

// ===== src/htc_ram.sv =====
module htc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/htc_div_cell.sv =====
module htc_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  htc_pkg::div_stage_type stage_in,
   output htc_pkg::div_stage_type stage_out
);

   htc_pkg::div_stage_type stage_ff;
   htc_pkg::div_stage_type stage_in_next;
   logic                   ge;

   always_comb begin
      ge = stage_in.rem >= stage_in.dsh;
      stage_in_next.valid = stage_in.valid;
      stage_in_next.rem   = ge ? stage_in.rem - stage_in.dsh : stage_in.rem;
      stage_in_next.dsh   = stage_in.dsh >> 1;
      stage_in_next.quot  = {stage_in.quot[htc_pkg::QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in_next.valid;
      end
      stage_ff.rem  <= stage_in_next.rem;
      stage_ff.dsh  <= stage_in_next.dsh;
      stage_ff.quot <= stage_in_next.quot;
   end

   assign stage_out = stage_ff;

endmodule

// ===== src/htc_divider.sv =====
module htc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  htc_pkg::div_stage_type div_in,
   output htc_pkg::div_stage_type div_out
);

   htc_pkg::div_stage_type link [htc_pkg::QUOT_W+1];

   assign link[0] = div_in;

   for (genvar g = 0; g < htc_pkg::QUOT_W; g++) begin : g_cell
      htc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (link[g]),
         .stage_out (link[g+1])
      );
   end

   assign div_out = link[htc_pkg::QUOT_W];

endmodule

// ===== src/homogeneous_triangle_clipper.sv =====
// Channel   Ports                         Direction  Handshake
// request   start, busy, req_data         in         start high while busy low
// result    rsp_strobe, rsp_data          out        one-cycle strobe, no stall
//
// Slots 0 and 1 only write the store; slot 3 is ignored.
// Slot 2 runs up to six plane passes, dividing once per crossing edge (17-cell
// divider chain, then six-field interpolation), then emits each vertex with its own
// strobe, or a culled transaction; the receiver never stalls.
// Reset is synchronous and clears the sequencer, bank select, divider and strobe.
// The store contents are undefined until written.
module homogeneous_triangle_clipper (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  htc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output htc_pkg::rsp_type rsp_data
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_PASS_INIT = 4'd1;
   localparam logic [3:0] S_PREV_WAIT = 4'd2;
   localparam logic [3:0] S_CUR_RD    = 4'd3;
   localparam logic [3:0] S_CUR_WAIT  = 4'd4;
   localparam logic [3:0] S_EVAL      = 4'd5;
   localparam logic [3:0] S_DIV_WAIT  = 4'd6;
   localparam logic [3:0] S_MUL       = 4'd7;
   localparam logic [3:0] S_ADD       = 4'd8;
   localparam logic [3:0] S_WR_NEW    = 4'd9;
   localparam logic [3:0] S_WR_CUR    = 4'd10;
   localparam logic [3:0] S_PASS_END  = 4'd11;
   localparam logic [3:0] S_EMIT_RD   = 4'd12;
   localparam logic [3:0] S_EMIT_CAP  = 4'd13;
   localparam logic [3:0] S_CULL      = 4'd14;

   localparam logic [htc_pkg::PLANE_W-1:0] LAST_PLANE =
      htc_pkg::PLANE_W'(htc_pkg::NUM_PLANES - 1);
   localparam logic [htc_pkg::IDX_W-1:0] MAX_IDX = htc_pkg::IDX_W'(htc_pkg::MAX_POLY_VERTS);
   localparam logic [2:0] LAST_FIELD = 3'(htc_pkg::NUM_FIELDS - 1);

   logic [3:0]                          state_ff, state_in;
   logic                                bank_ff, bank_in;
   logic [htc_pkg::PLANE_W-1:0]         plane_ff, plane_in;
   logic [htc_pkg::IDX_W-1:0]           n_ff, n_in;
   logic [htc_pkg::IDX_W-1:0]           i_ff, i_in;
   logic [htc_pkg::IDX_W-1:0]           outn_ff, outn_in;
   htc_pkg::vert_type                   pv_ff, pv_in;
   htc_pkg::vert_type                   cv_ff, cv_in;
   htc_pkg::vert_type                   nv_ff, nv_in;
   logic signed [htc_pkg::DIST_W-1:0]   pd_ff, pd_in;
   logic signed [htc_pkg::DIST_W-1:0]   cd_ff, cd_in;
   logic [htc_pkg::QUOT_W-1:0]          tq_ff, tq_in;
   logic [2:0]                          fld_ff, fld_in;
   logic [htc_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   htc_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic                                wr_en;
   logic [htc_pkg::ADDR_W-1:0]          wr_addr;
   htc_pkg::vert_type                   wr_data;
   logic [htc_pkg::ADDR_W-1:0]          rd_addr;
   htc_pkg::vert_type                   rd_data;
   htc_pkg::div_stage_type              div_in;
   htc_pkg::div_stage_type              div_out;

   htc_pkg::vert_type                   req_vert;
   logic                                accept;
   logic [htc_pkg::IDX_W-1:0]           last_idx;
   logic signed [htc_pkg::DEN_W-1:0]    diff;
   logic [htc_pkg::DEN_W-1:0]           num;
   logic [htc_pkg::DEN_W-1:0]           den;
   logic signed [htc_pkg::DELTA_W-1:0]  delta;
   logic signed [htc_pkg::DELTA_W-1:0]  a_ext;
   logic [htc_pkg::DELTA_W-1:0]         mag;
   logic [htc_pkg::PROD_W-1:0]          rounded;
   logic [htc_pkg::DELTA_W-1:0]         r_mag;
   logic signed [htc_pkg::DELTA_W-1:0]  lerp_res;

   htc_ram #(.WIDTH(htc_pkg::VERT_W), .DEPTH(htc_pkg::STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   htc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      req_vert[0] = req_data.pos_x;
      req_vert[1] = req_data.pos_y;
      req_vert[2] = req_data.pos_z;
      req_vert[3] = req_data.pos_w;
      req_vert[4] = req_data.attr_a;
      req_vert[5] = req_data.attr_b;

      last_idx = n_ff - 1'b1;
      diff     = htc_pkg::DEN_W'(pd_ff) - htc_pkg::DEN_W'(cd_ff);
      num      = pd_ff < 0 ? htc_pkg::DEN_W'(-pd_ff) : htc_pkg::DEN_W'(pd_ff);
      den      = diff < 0 ? htc_pkg::DEN_W'(-diff) : htc_pkg::DEN_W'(diff);

      div_in.valid = 1'b0;
      div_in.rem   = (htc_pkg::REM_W'(num) << htc_pkg::FRAC_BITS)
                     + htc_pkg::REM_W'(den >> 1);
      div_in.dsh   = htc_pkg::REM_W'(den) << htc_pkg::FRAC_BITS;
      div_in.quot  = '0;

      a_ext    = htc_pkg::DELTA_W'(signed'(pv_ff[fld_ff]));
      delta    = htc_pkg::DELTA_W'(signed'(cv_ff[fld_ff])) - a_ext;
      mag      = delta < 0 ? htc_pkg::DELTA_W'(-delta) : htc_pkg::DELTA_W'(delta);
      rounded  = (prod_ff + htc_pkg::PROD_W'(1 << (htc_pkg::FRAC_BITS - 1)))
                 >> htc_pkg::FRAC_BITS;
      r_mag    = rounded[htc_pkg::DELTA_W-1:0];
      lerp_res = neg_ff ? a_ext - signed'(r_mag) : a_ext + signed'(r_mag);

      state_in      = state_ff;
      bank_in       = bank_ff;
      plane_in      = plane_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      outn_in       = outn_ff;
      pv_in         = pv_ff;
      cv_in         = cv_ff;
      nv_in         = nv_ff;
      pd_in         = pd_ff;
      cd_in         = cd_ff;
      tq_in         = tq_ff;
      fld_in        = fld_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.vertex_slot inside {2'd0, 2'd1, htc_pkg::SLOT_LAST})) begin
               wr_en   = 1'b1;
               wr_addr = htc_pkg::store_addr(bank_ff,
                                             htc_pkg::IDX_W'(req_data.vertex_slot));
               wr_data = req_vert;
               if (req_data.vertex_slot == htc_pkg::SLOT_LAST) begin
                  n_in     = htc_pkg::IDX_W'(3);
                  plane_in = '0;
                  state_in = S_PASS_INIT;
               end
            end
         end
         S_PASS_INIT: begin
            rd_addr  = htc_pkg::store_addr(bank_ff, last_idx);
            i_in     = '0;
            outn_in  = '0;
            state_in = S_PREV_WAIT;
         end
         S_PREV_WAIT: begin
            pv_in    = rd_data;
            pd_in    = htc_pkg::plane_dist(rd_data, plane_ff);
            state_in = S_CUR_RD;
         end
         S_CUR_RD: begin
            rd_addr  = htc_pkg::store_addr(bank_ff, i_ff);
            state_in = S_CUR_WAIT;
         end
         S_CUR_WAIT: begin
            cv_in    = rd_data;
            cd_in    = htc_pkg::plane_dist(rd_data, plane_ff);
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if ((pd_ff >= 0) != (cd_ff >= 0)) begin
               div_in.valid = 1'b1;
               state_in     = S_DIV_WAIT;
            end else begin
               state_in = S_WR_CUR;
            end
         end
         S_DIV_WAIT: begin
            if (div_out.valid) begin
               tq_in    = div_out.quot;
               fld_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            neg_in   = delta < 0;
            prod_in  = htc_pkg::PROD_W'(mag) * htc_pkg::PROD_W'(tq_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            nv_in[fld_ff] = lerp_res[htc_pkg::VAL_W-1:0];
            if (fld_ff == LAST_FIELD) begin
               state_in = S_WR_NEW;
            end else begin
               fld_in   = fld_ff + 3'd1;
               state_in = S_MUL;
            end
         end
         S_WR_NEW: begin
            if (outn_ff < MAX_IDX) begin
               wr_en   = 1'b1;
               wr_addr = htc_pkg::store_addr(!bank_ff, outn_ff);
               wr_data = nv_ff;
               outn_in = outn_ff + 1'b1;
            end
            state_in = S_WR_CUR;
         end
         S_WR_CUR: begin
            if (cd_ff >= 0 && outn_ff < MAX_IDX) begin
               wr_en   = 1'b1;
               wr_addr = htc_pkg::store_addr(!bank_ff, outn_ff);
               wr_data = cv_ff;
               outn_in = outn_ff + 1'b1;
            end
            pv_in = cv_ff;
            pd_in = cd_ff;
            if (i_ff == last_idx) begin
               state_in = S_PASS_END;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_CUR_RD;
            end
         end
         S_PASS_END: begin
            bank_in = !bank_ff;
            n_in    = outn_ff;
            i_in    = '0;
            if (outn_ff == '0) begin
               state_in = S_CULL;
            end else if (plane_ff == LAST_PLANE) begin
               state_in = S_EMIT_RD;
            end else begin
               plane_in = plane_ff + 1'b1;
               state_in = S_PASS_INIT;
            end
         end
         S_EMIT_RD: begin
            rd_addr  = htc_pkg::store_addr(bank_ff, i_ff);
            state_in = S_EMIT_CAP;
         end
         S_EMIT_CAP: begin
            rsp_strobe_in           = 1'b1;
            rsp_data_in.out_x       = rd_data[0];
            rsp_data_in.out_y       = rd_data[1];
            rsp_data_in.out_z       = rd_data[2];
            rsp_data_in.out_w       = rd_data[3];
            rsp_data_in.out_attr_a  = rd_data[4];
            rsp_data_in.out_attr_b  = rd_data[5];
            rsp_data_in.last_vertex = (i_ff == last_idx);
            rsp_data_in.culled      = 1'b0;
            if (i_ff == last_idx) begin
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_EMIT_RD;
            end
         end
         S_CULL: begin
            rsp_strobe_in           = 1'b1;
            rsp_data_in             = '0;
            rsp_data_in.last_vertex = 1'b1;
            rsp_data_in.culled      = 1'b1;
            state_in                = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bank_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      plane_ff    <= plane_in;
      n_ff        <= n_in;
      i_ff        <= i_in;
      outn_ff     <= outn_in;
      pv_ff       <= pv_in;
      cv_ff       <= cv_in;
      nv_ff       <= nv_in;
      pd_ff       <= pd_in;
      cd_ff       <= cd_in;
      tq_ff       <= tq_in;
      fld_ff      <= fld_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_div_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_out.valid |-> state_ff == S_DIV_WAIT)
      else $error("divider result arrived outside the wait state");

   a_outn_bounded: assert property (@(posedge clock) disable iff (reset)
      outn_ff <= MAX_IDX)
      else $error("clipped polygon exceeds the store row");

   a_culled_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.culled |-> rsp_data_ff.last_vertex)
      else $error("culled transaction not marked last");

   a_culled_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.culled |=> !rsp_strobe_ff)
      else $error("result followed a culled transaction");
`endif

endmodule
